/* rtl/core/qrs_pkg.sv */
// Shared types and constants of the quadratic root solver.
// No dependencies; every other file of the block imports this package.
package qrs_pkg;

  // Field and datapath widths.
  localparam int COEF_W = 16;
  localparam int D_W = 35;
  localparam int DM_W = 33;
  localparam int ROOT_W = 32;
  localparam int MAG_W = 34;
  localparam int RAD_W = 64;
  localparam int SQRT_EXTRA = 15;
  localparam int QUOT_W = 33;
  localparam int DEN_W = 32;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;

  // Default output scale.
  localparam int OUT_FRAC_BITS_DEF = 16;

  // Status codes.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SAT = 2'd1;
  localparam logic [1:0] STATUS_AZERO = 2'd2;

  // One classified equation as it waits in the queue.
  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [D_W-1:0] d;
  } qrs_entry_t;

  // Data that travels beside the square root.
  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic d_neg;
    logic d_zero;
    logic a_zero;
  } qrs_side_t;

  // Data that travels beside the first divider lane.
  typedef struct packed {
    logic cplx;
    logic eq;
    logic a_zero;
    logic neg0;
  } qrs_tag_t;

  // One finished result.
  typedef struct packed {
    logic [ROOT_W-1:0] r1re;
    logic [ROOT_W-1:0] r1im;
    logic [ROOT_W-1:0] r2re;
    logic [ROOT_W-1:0] r2im;
    logic cplx;
    logic eq;
    logic [1:0] status;
  } qrs_result_t;

endpackage

/* rtl/core/qrs_fifo.sv */
// Short queue of classified equations between the front and the back.
// Depends on qrs_pkg.
module qrs_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  qrs_pkg::qrs_entry_t  wr_data,
  input  logic                 pop,
  output qrs_pkg::qrs_entry_t  rd_data,
  output logic                 empty,
  output logic [qrs_pkg::FIFO_AW:0] level
);
  import qrs_pkg::*;

  qrs_entry_t mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: level <= level + 1'b1;
        2'b01: level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty = (level == '0);

  // The front reserves room before it accepts, so a write never meets a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level < (FIFO_AW+1)'(FIFO_DEPTH)) || pop)
    else $error("queue written while full");

endmodule

/* rtl/core/qrs_front.sv */
// Front part: accepts coefficients, forms the discriminant and queues the equation.
// Depends on qrs_pkg.
module qrs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // coef_a, coef_b, coef_c from bit 0 up
  input  logic [qrs_pkg::FIFO_AW:0] fifo_level,
  output logic                 push,
  output qrs_pkg::qrs_entry_t  entry
);
  import qrs_pkg::*;

  logic f1_valid;
  logic signed [COEF_W-1:0] f1_a;
  logic signed [COEF_W-1:0] f1_b;
  logic signed [31:0] f1_bb;
  logic signed [31:0] f1_ac;
  logic signed [COEF_W-1:0] in_a;
  logic signed [COEF_W-1:0] in_b;
  logic signed [COEF_W-1:0] in_c;
  logic signed [D_W-1:0] disc;
  logic [FIFO_AW+1:0] occupancy;
  logic accept;

  assign in_a = $signed(s_axis_tdata[15:0]);
  assign in_b = $signed(s_axis_tdata[31:16]);
  assign in_c = $signed(s_axis_tdata[47:32]);

  // Accept only while the queue plus the item in flight leave a free slot.
  assign occupancy = (FIFO_AW+2)'(fifo_level) + (FIFO_AW+2)'(f1_valid);
  assign s_axis_tready = (occupancy < (FIFO_AW+2)'(FIFO_DEPTH));
  assign accept = s_axis_tvalid && s_axis_tready;

  // Products of the discriminant.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_a <= in_a;
      f1_b <= in_b;
      f1_bb <= in_b * in_b;
      f1_ac <= in_a * in_c;
    end
  end

  // Discriminant b*b - 4ac, exact.
  assign disc = D_W'(f1_bb) - (D_W'(f1_ac) <<< 2);

  assign push = f1_valid;
  assign entry.a = f1_a;
  assign entry.b = f1_b;
  assign entry.d = disc;

endmodule

/* rtl/core/qrs_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [qrs_pkg::RAD_W-1:0] in_rad,
  input  qrs_pkg::qrs_side_t        in_side,
  output logic                      out_valid,
  output logic [qrs_pkg::ROOT_W-1:0] out_root,
  output qrs_pkg::qrs_side_t        out_side
);
  import qrs_pkg::*;

  localparam int STAGES = RAD_W / 2;
  localparam int REM_W = ROOT_W + 3;

  // Stage registers; stage k holds the state after k digit steps.
  logic              vld  [1:STAGES];
  logic [REM_W-1:0]  rem  [1:STAGES];
  logic [ROOT_W-1:0] root [1:STAGES];
  logic [RAD_W-1:0]  rad  [1:STAGES];
  qrs_side_t         side [1:STAGES];

  // Operands seen by each digit step; step 0 works on the pipeline input.
  logic [REM_W-1:0]  crem  [0:STAGES-1];
  logic [ROOT_W-1:0] croot [0:STAGES-1];
  logic [RAD_W-1:0]  crad  [0:STAGES-1];

  logic [REM_W-1:0]  r2    [0:STAGES-1];
  logic [REM_W-1:0]  trial [0:STAGES-1];
  logic [REM_W-1:0]  nrem  [0:STAGES-1];
  logic [ROOT_W-1:0] nroot [0:STAGES-1];

  // One digit step per stage: bring down two radicand bits and try a one.
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        crem[k] = '0;
        croot[k] = '0;
        crad[k] = in_rad;
      end else begin
        crem[k] = rem[k];
        croot[k] = root[k];
        crad[k] = rad[k];
      end
      r2[k] = {crem[k][REM_W-3:0], crad[k][RAD_W-1 -: 2]};
      trial[k] = REM_W'({croot[k], 2'b01});
      if (r2[k] >= trial[k]) begin
        nrem[k] = r2[k] - trial[k];
        nroot[k] = {croot[k][ROOT_W-2:0], 1'b1};
      end else begin
        nrem[k] = r2[k];
        nroot[k] = {croot[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STAGES; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[1] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      side[1] <= in_side;
      for (int k = 0; k < STAGES; k++) begin
        rem[k+1] <= nrem[k];
        root[k+1] <= nroot[k];
        rad[k+1] <= {crad[k][RAD_W-3:0], 2'b00};
      end
      for (int k = 1; k < STAGES; k++) begin
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_root = root[STAGES];
  assign out_side = side[STAGES];

endmodule

/* rtl/core/qrs_div.sv */
// Pipelined rounding divider lane: round(mag * 2^OUT_FRAC_BITS / (|a| * 2^16)).
// Depends on qrs_pkg.
module qrs_div #(
  parameter int OUT_FRAC_BITS = qrs_pkg::OUT_FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [qrs_pkg::MAG_W-1:0]  in_mag,
  input  logic [qrs_pkg::COEF_W-1:0] in_amag,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [qrs_pkg::QUOT_W-1:0] out_quot,
  output logic                       out_ovf,
  output logic [SIDE_W-1:0]          out_side
);
  import qrs_pkg::*;

  localparam int NW = MAG_W + 1 + OUT_FRAC_BITS;
  localparam int PW = NW - QUOT_W;
  localparam int STAGES = QUOT_W;

  logic [NW-1:0]     n_full;
  logic [PW-1:0]     prefix;
  logic [DEN_W-1:0]  den_in;

  logic              vld  [0:STAGES];
  logic [DEN_W-1:0]  rem  [0:STAGES];
  logic [QUOT_W-1:0] nlo  [0:STAGES];
  logic [QUOT_W-1:0] quot [0:STAGES];
  logic [DEN_W-1:0]  den  [0:STAGES];
  logic              ovf  [0:STAGES];
  logic [SIDE_W-1:0] side [0:STAGES];

  logic [QUOT_W-1:0] r2   [0:STAGES-1];
  logic              ge   [0:STAGES-1];
  logic [DEN_W-1:0]  nrem [0:STAGES-1];

  // Scaled numerator with the half-divisor added for rounding.
  assign n_full = (NW'(in_mag) << OUT_FRAC_BITS) + (NW'(in_amag) << SQRT_EXTRA);
  assign den_in = DEN_W'(in_amag) << (SQRT_EXTRA + 1);
  assign prefix = n_full[NW-1:QUOT_W];

  // Restoring steps, one quotient bit each.
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      r2[k] = {rem[k], nlo[k][QUOT_W-1]};
      ge[k] = (r2[k] >= {1'b0, den[k]});
      if (ge[k]) begin
        nrem[k] = DEN_W'(r2[k] - {1'b0, den[k]});
      end else begin
        nrem[k] = r2[k][DEN_W-1:0];
      end
    end
  end

  // Stage valid bits, entry stage included.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STAGES; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 0; k < STAGES; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // Entry stage flags a quotient beyond its field width at once; later stages divide.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= DEN_W'(prefix);
      nlo[0] <= n_full[QUOT_W-1:0];
      quot[0] <= '0;
      den[0] <= den_in;
      ovf[0] <= (DEN_W'(prefix) >= den_in);
      side[0] <= in_side;
      for (int k = 0; k < STAGES; k++) begin
        rem[k+1] <= nrem[k];
        nlo[k+1] <= {nlo[k][QUOT_W-2:0], 1'b0};
        quot[k+1] <= {quot[k][QUOT_W-2:0], ge[k]};
        den[k+1] <= den[k];
        ovf[k+1] <= ovf[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_quot = quot[STAGES];
  assign out_ovf = ovf[STAGES];
  assign out_side = side[STAGES];

endmodule

/* rtl/core/qrs_back.sv */
// Back part: square root, numerators, two divider lanes, saturation and output register.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
module qrs_back #(
  parameter int OUT_FRAC_BITS = qrs_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qrs_pkg::qrs_entry_t  fifo_data,
  input  logic                 fifo_empty,
  output logic                 fifo_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output qrs_pkg::qrs_result_t res
);
  import qrs_pkg::*;

  logic adv;
  logic d_neg;
  logic [D_W-1:0] d_abs;

  logic b0_valid;
  logic [RAD_W-1:0] b0_rad;
  qrs_side_t b0_side;

  logic sq_valid;
  logic [ROOT_W-1:0] sq_root;
  qrs_side_t sq_side;

  logic signed [D_W-1:0] nb;
  logic signed [D_W-1:0] s_ext;
  logic signed [D_W-1:0] num0;
  logic signed [D_W-1:0] num1;
  logic [D_W-1:0] abs0;
  logic [D_W-1:0] abs1;
  logic a_neg;
  qrs_tag_t tag_next;

  logic p_valid;
  logic [MAG_W-1:0] p_mag0;
  logic [MAG_W-1:0] p_mag1;
  logic [COEF_W-1:0] p_amag;
  qrs_tag_t p_tag;
  logic p_neg1;

  logic dv0_valid;
  logic [QUOT_W-1:0] dv0_quot;
  logic dv0_ovf;
  qrs_tag_t dv0_tag;
  logic dv1_valid;
  logic [QUOT_W-1:0] dv1_quot;
  logic dv1_ovf;
  logic dv1_neg;

  logic [ROOT_W:0] sr0;
  logic [ROOT_W:0] sr1;
  logic [ROOT_W:0] sr1n;
  qrs_result_t res_next;

  // Signed root from magnitude quotient, clamped to the 32-bit range; top bit flags a clamp.
  function automatic logic [ROOT_W:0] sat_root(input logic neg, input logic [QUOT_W-1:0] q,
                                               input logic ovf);
    logic [ROOT_W:0] r;
    if (!neg) begin
      if (ovf || q > QUOT_W'(33'h07FFFFFFF)) begin
        r = {1'b1, 32'h7FFFFFFF};
      end else begin
        r = {1'b0, q[ROOT_W-1:0]};
      end
    end else begin
      if (ovf || q > QUOT_W'(33'h080000000)) begin
        r = {1'b1, 32'h80000000};
      end else begin
        r = {1'b0, ROOT_W'(~q[ROOT_W-1:0] + 32'd1)};
      end
    end
    return r;
  endfunction

  // The whole back advances together; the output register parts it from the sink.
  assign adv = !res_valid || res_ready;
  assign fifo_pop = adv && !fifo_empty;

  // Radicand |d| * 2^30.
  assign d_neg = fifo_data.d[D_W-1];
  assign d_abs = d_neg ? (~fifo_data.d + 1'b1) : fifo_data.d;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid <= 1'b0;
    end else if (adv) begin
      b0_valid <= fifo_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_rad <= {1'b0, d_abs[DM_W-1:0], {(2*SQRT_EXTRA){1'b0}}};
      b0_side.a <= fifo_data.a;
      b0_side.b <= fifo_data.b;
      b0_side.d_neg <= d_neg;
      b0_side.d_zero <= (fifo_data.d == '0);
      b0_side.a_zero <= (fifo_data.a == '0);
    end
  end

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (b0_valid),
    .in_rad    (b0_rad),
    .in_side   (b0_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Numerators: real pair -b*2^15 +/- s, complex pair -b*2^15 and s.
  always_comb begin
    a_neg = sq_side.a[COEF_W-1];
    nb = -(D_W'($signed(sq_side.b)) <<< SQRT_EXTRA);
    s_ext = $signed(D_W'(sq_root));
    if (sq_side.d_neg) begin
      num0 = nb;
      num1 = s_ext;
    end else begin
      num0 = nb + s_ext;
      num1 = nb - s_ext;
    end
    abs0 = num0[D_W-1] ? D_W'(-num0) : num0;
    abs1 = num1[D_W-1] ? D_W'(-num1) : num1;
    tag_next.cplx = sq_side.d_neg;
    tag_next.eq = sq_side.d_zero;
    tag_next.a_zero = sq_side.a_zero;
    tag_next.neg0 = num0[D_W-1] ^ a_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mag0 <= abs0[MAG_W-1:0];
      p_mag1 <= abs1[MAG_W-1:0];
      p_amag <= a_neg ? COEF_W'(-sq_side.a) : sq_side.a;
      p_tag <= tag_next;
      p_neg1 <= num1[D_W-1] ^ a_neg;
    end
  end

  // Two divider lanes in step.
  qrs_div #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .SIDE_W        ($bits(qrs_tag_t))
  ) u_div0 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p_valid),
    .in_mag    (p_mag0),
    .in_amag   (p_amag),
    .in_side   (p_tag),
    .out_valid (dv0_valid),
    .out_quot  (dv0_quot),
    .out_ovf   (dv0_ovf),
    .out_side  (dv0_tag)
  );

  qrs_div #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .SIDE_W        (1)
  ) u_div1 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p_valid),
    .in_mag    (p_mag1),
    .in_amag   (p_amag),
    .in_side   (p_neg1),
    .out_valid (dv1_valid),
    .out_quot  (dv1_quot),
    .out_ovf   (dv1_ovf),
    .out_side  (dv1_neg)
  );

  // Sign, saturation and field selection.
  always_comb begin
    sr0 = sat_root(dv0_tag.neg0, dv0_quot, dv0_ovf);
    sr1 = sat_root(dv1_neg, dv1_quot, dv1_ovf);
    sr1n = sat_root(!dv1_neg, dv1_quot, dv1_ovf);
    res_next = '0;
    if (dv0_tag.a_zero) begin
      res_next.status = STATUS_AZERO;
    end else if (dv0_tag.cplx) begin
      res_next.r1re = sr0[ROOT_W-1:0];
      res_next.r2re = sr0[ROOT_W-1:0];
      res_next.r1im = sr1[ROOT_W-1:0];
      res_next.r2im = sr1n[ROOT_W-1:0];
      res_next.cplx = 1'b1;
      res_next.status = (sr0[ROOT_W] || sr1[ROOT_W] || sr1n[ROOT_W]) ? STATUS_SAT : STATUS_OK;
    end else begin
      res_next.r1re = sr0[ROOT_W-1:0];
      res_next.r2re = sr1[ROOT_W-1:0];
      res_next.eq = dv0_tag.eq;
      res_next.status = (sr0[ROOT_W] || sr1[ROOT_W]) ? STATUS_SAT : STATUS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dv0_valid && dv1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/core/quadratic_root_solver_unit.sv */
// Quadratic root solver: for each a, b, c (signed Q8.8) returns both roots in signed
// Q(32-OUT_FRAC_BITS).OUT_FRAC_BITS, real or a complex pair, with equal-root and status flags.
// Depends on qrs_pkg, qrs_front, qrs_fifo and qrs_back.
//
// The unit accepts one equation per clock and returns one result per clock for as long as
// the output side takes them. The path runs through the multiplier register in the front,
// the four-entry queue, then in the back one register stage, 32 square-root stages (one
// root bit each), one numerator stage, 34 divider stages (an entry stage that flags
// overflow, then one quotient bit each) and the output register.
// The divider and square-root pipelines set the latency; the rate is one item a cycle. A
// stalled output holds the back pipeline, while the front keeps taking items until the queue
// is full. There is no configuration and no state carried between equations.
module quadratic_root_solver_unit #(
  parameter int OUT_FRAC_BITS = qrs_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // root_one_real, root_one_imag, root_two_real,
                                        // root_two_imag, 32 bits each from bit 0 up
  output logic [3:0]    m_axis_tuser    // roots_complex [0], roots_equal [1], status_code [3:2]
);
  import qrs_pkg::*;

  logic fifo_push;
  qrs_entry_t fifo_wr;
  logic fifo_pop;
  qrs_entry_t fifo_rd;
  logic fifo_empty;
  logic [FIFO_AW:0] fifo_level;
  qrs_result_t res;

  qrs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .fifo_level    (fifo_level),
    .push          (fifo_push),
    .entry         (fifo_wr)
  );

  qrs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (fifo_push),
    .wr_data (fifo_wr),
    .pop     (fifo_pop),
    .rd_data (fifo_rd),
    .empty   (fifo_empty),
    .level   (fifo_level)
  );

  qrs_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_data  (fifo_rd),
    .fifo_empty (fifo_empty),
    .fifo_pop   (fifo_pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // Output packing.
  assign m_axis_tdata = {res.r2im, res.r2re, res.r1im, res.r1re};
  assign m_axis_tuser = {res.status, res.eq, res.cplx};

  // A result is never both a complex pair and an equal real pair.
  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(res.cplx && res.eq))
    else $error("complex and equal flags both set");

  // A zero leading coefficient clears every root field.
  a_azero_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (res.status == STATUS_AZERO) |-> (m_axis_tdata == '0) && !res.cplx)
    else $error("roots not cleared for zero leading coefficient");

  // Equal real roots come from a zero square root, so both real parts agree.
  a_equal_roots: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.eq |-> (res.r1re == res.r2re))
    else $error("equal roots differ");

  // A complex pair shares its real part.
  a_cplx_real: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.cplx |-> (res.r1re == res.r2re))
    else $error("complex pair real parts differ");

endmodule

/* bench/qrs_checker.sv */
// Checker for the quadratic root solver: watches both stream channels, predicts each result
// from the accepted coefficients and compares it field by field. Depends on qrs_pkg.
module qrs_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic [3:0]   m_axis_tuser,
  output int           fail_count,
  output int           roots_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int OUT_FRAC = OUT_FRAC_BITS_DEF;

  qrs_result_t expected_roots[$];

  assign roots_pending = expected_roots.size();

  // Integer square root, truncated.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Divide a numerator by 2a with the extra root scale, round half away, saturate.
  function automatic logic [31:0] scaled_quotient(input longint num, input longint a,
                                                  inout logic sat);
    logic neg;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] q;
    neg = (num < 0) != (a < 0);
    mag = 64'(num < 0 ? -num : num) << OUT_FRAC;
    den = (64'(a < 0 ? -a : a) << 1) << SQRT_EXTRA;
    q = (2 * mag + den) / (2 * den);
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        q = 64'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      sat = 1'b1;
      q = 64'h8000_0000;
    end
    return 32'd0 - q[31:0];
  endfunction

  function automatic qrs_result_t solve_quadratic(input logic [47:0] coefs);
    qrs_result_t res;
    longint a, b, c, d, s, nb;
    logic sat;
    a = longint'($signed(coefs[15:0]));
    b = longint'($signed(coefs[31:16]));
    c = longint'($signed(coefs[47:32]));
    res = '0;
    sat = 1'b0;
    if (a == 0) begin
      res.status = STATUS_AZERO;
    end else begin
      d = b * b - 4 * a * c;
      s = longint'(floor_sqrt(64'(d < 0 ? -d : d) << (2 * SQRT_EXTRA)));
      nb = -b * (longint'(1) << SQRT_EXTRA);
      if (d >= 0) begin
        res.r1re = scaled_quotient(nb + s, a, sat);
        res.r2re = scaled_quotient(nb - s, a, sat);
        res.eq = (d == 0);
      end else begin
        res.cplx = 1'b1;
        res.r1re = scaled_quotient(nb, a, sat);
        res.r2re = res.r1re;
        res.r1im = scaled_quotient(s, a, sat);
        res.r2im = scaled_quotient(-s, a, sat);
      end
      res.status = sat ? STATUS_SAT : STATUS_OK;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Record each input transfer, then check each output transfer against the oldest entry.
  always @(posedge clk) begin
    qrs_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) expected_roots.push_back(solve_quadratic(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = expected_roots.pop_front();
          if (m_axis_tdata[31:0] !== want.r1re)
            report_mismatch("root_one_real", m_axis_tdata[31:0], want.r1re);
          if (m_axis_tdata[63:32] !== want.r1im)
            report_mismatch("root_one_imag", m_axis_tdata[63:32], want.r1im);
          if (m_axis_tdata[95:64] !== want.r2re)
            report_mismatch("root_two_real", m_axis_tdata[95:64], want.r2re);
          if (m_axis_tdata[127:96] !== want.r2im)
            report_mismatch("root_two_imag", m_axis_tdata[127:96], want.r2im);
          if (m_axis_tuser[0] !== want.cplx)
            report_mismatch("roots_complex", 32'(m_axis_tuser[0]), 32'(want.cplx));
          if (m_axis_tuser[1] !== want.eq)
            report_mismatch("roots_equal", 32'(m_axis_tuser[1]), 32'(want.eq));
          if (m_axis_tuser[3:2] !== want.status)
            report_mismatch("status_code", 32'(m_axis_tuser[3:2]), 32'(want.status));
        end
      end
    end
  end
endmodule

/* bench/tb_quadratic_root_solver_unit.sv */
// Top of the quadratic root solver testbench: clock, reset, coefficient stimulus, output
// back-pressure and the verdict. Depends on qrs_pkg, quadratic_root_solver_unit, qrs_checker.
module tb_quadratic_root_solver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 71;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  int fail_count;
  int roots_pending;
  int send_idle_pct;
  int take_idle_pct;
  bit hold_output;
  int quiet_cycles;

  quadratic_root_solver_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  qrs_checker checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .roots_pending(roots_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side: random stalls, or a long hold-off when asked.
  initial m_axis_tready = 1'b0;
  always @(posedge clk) begin
    if (rst || hold_output) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[quadratic_root_solver_unit] ERROR");
      $finish;
    end
  end

  // Offer one equation and hold it until the transfer.
  task automatic send_equation(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 48'($urandom);
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_coef();
    case ($urandom_range(5))
      0: return 16'($urandom_range(15)) - 16'd8;
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      2: return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [15:0] a, b, c;
    repeat (count) begin
      a = random_coef();
      b = random_coef();
      c = random_coef();
      // Some equations built with a zero discriminant: b = 2k, a = 1, c = k*k.
      if ($urandom_range(9) == 0) begin
        a = 16'd1;
        b = 16'($urandom_range(180)) * 16'd2;
        c = (b / 16'd2) * (b / 16'd2);
        if ($urandom_range(1)) b = -b;
      end
      send_equation(a, b, c);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_output = 1'b0;
    send_idle_pct = 0;
    take_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, zero leading coefficient, equal, real and complex roots.
    send_equation(16'h0000, 16'h0100, 16'h0100);
    send_equation(16'h0000, 16'h0000, 16'h0000);
    send_equation(16'h0100, 16'h0000, 16'h0000);
    send_equation(16'h0100, 16'hFE00, 16'h0100);
    send_equation(16'h0100, 16'h0000, 16'hFF00);
    send_equation(16'h0100, 16'h0000, 16'h0100);
    send_equation(16'hFF00, 16'h0300, 16'h0200);
    send_equation(16'h0001, 16'h7FFF, 16'h0000);
    send_equation(16'h0001, 16'h8000, 16'h8000);
    send_equation(16'h0001, 16'h0000, 16'h7FFF);
    send_equation(16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_equation(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_equation(16'h8000, 16'h8000, 16'h8000);
    send_equation(16'h8000, 16'h0001, 16'h7FFF);
    send_equation(16'h7FFF, 16'h0000, 16'h8000);
    send_equation(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_equation(16'h0001, 16'h0002, 16'h0001);
    send_equation(16'hAAAA, 16'h5555, 16'hAAAA);
    send_equation(16'h5555, 16'hAAAA, 16'h5555);

    // Long output hold-off while the input keeps offering, so the input backs up.
    hold_output <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_output <= 1'b0;
      end
      random_phase(120);
    join

    send_idle_pct = 17;
    take_idle_pct = 50;
    random_phase(160);
    stop_sending();
    // Pause until every expected result has come back.
    while (roots_pending != 0) @(posedge clk);

    send_idle_pct = 50;
    take_idle_pct = 17;
    random_phase(160);
    send_idle_pct = 0;
    take_idle_pct = 0;
    random_phase(160);
    stop_sending();

    while (roots_pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("[quadratic_root_solver_unit] OK");
    else $display("[quadratic_root_solver_unit] ERROR");
    $finish;
  end
endmodule
